### rtl/vax_branch_target_scanner_unit_defines.svh
// Assertion macros shared by the branch target scanner RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef VAX_BRANCH_TARGET_SCANNER_UNIT_DEFINES_SVH
`define VAX_BRANCH_TARGET_SCANNER_UNIT_DEFINES_SVH

// same-cycle implication
`define VBTS_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define VBTS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/vbts_pkg.sv
// Types, codes and the opcode ROM of the VAX branch target scanner.
// No dependencies.
package vbts_pkg;

    localparam int ADDR_WIDTH_DEF = 32;
    localparam int REC_FIFO_DEPTH = 4;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_REPORT_CALLS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_BRANCHES = 2'd1;

    // opcode class, bit 2 marks "last operand is a branch displacement"
    localparam logic [2:0] K_B  = 3'd0;
    localparam logic [2:0] K_C  = 3'd1;
    localparam logic [2:0] K_R  = 3'd2;
    localparam logic [2:0] K_O  = 3'd3;
    localparam logic [2:0] K_BD = 3'd4;

    localparam logic [1:0] CLS_B = 2'd0;
    localparam logic [1:0] CLS_C = 2'd1;
    localparam logic [1:0] CLS_R = 2'd2;

    localparam logic [1:0] REC_BRANCH = 2'd0;
    localparam logic [1:0] REC_CALL   = 2'd1;
    localparam logic [1:0] REC_END    = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_CASE_LIMIT = 2'd1;
    localparam logic [1:0] ST_TRUNC      = 2'd2;

    // operand kinds: general specifier by size, branch displacement, case table
    typedef enum logic [3:0] {
        NO, GB, GW, GL, GF, GQ, BRB, BRW, CSW
    } op_t;

    typedef enum logic [1:0] {
        PH_OPCODE, PH_SPEC, PH_EXT, PH_CASE
    } phase_t;

    typedef enum logic [1:0] {
        XK_SKIP, XK_IMM, XK_REL
    } xk_t;

    typedef struct packed {
        logic [2:0]    kind;
        op_t [5:0]     ops;
    } rom_ent_t;

    typedef struct packed {
        logic [7:0]  code_byte;
        logic        first_byte;
        logic [31:0] region_addr;
        logic        last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [31:0] instr_addr;
        logic [31:0] target_addr;
        logic [1:0]  status;
        logic        last_of_run;
    } rec_t;

    typedef struct packed {
        logic v0;
        rec_t r0;
        logic v1;
        rec_t r1;
    } push_t;

    typedef struct packed {
        logic report_calls;
        logic report_branches;
    } cfg_t;

    function automatic rom_ent_t mk(input logic [2:0] k, input op_t o0, input op_t o1,
                                    input op_t o2, input op_t o3, input op_t o4,
                                    input op_t o5);
        rom_ent_t e;
        e.kind   = k;
        e.ops[0] = o0;
        e.ops[1] = o1;
        e.ops[2] = o2;
        e.ops[3] = o3;
        e.ops[4] = o4;
        e.ops[5] = o5;
        return e;
    endfunction

    function automatic rom_ent_t opcode_rom(input logic [7:0] opc);
        rom_ent_t e;
        case (opc)
            8'h02, 8'h04, 8'h05: e = mk(K_R, NO, NO, NO, NO, NO, NO);
            8'h08, 8'h09, 8'h20, 8'h22, 8'h37, 8'h39:
                e = mk(K_O, GW, GB, GW, GB, NO, NO);
            8'h0a: e = mk(K_O, GL, GL, GL, GL, GL, GL);
            8'h0b: e = mk(K_O, GB, GL, GW, GB, NO, NO);
            8'h0c, 8'h0d, 8'h3a, 8'h3b: e = mk(K_O, GB, GW, GB, NO, NO, NO);
            8'h0e: e = mk(K_O, GB, GB, NO, NO, NO, NO);
            8'h0f, 8'h98, 8'h9a, 8'h9e: e = mk(K_O, GB, GL, NO, NO, NO, NO);
            8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h18, 8'h19, 8'h1a, 8'h1b,
            8'h1c, 8'h1d, 8'h1e, 8'h1f:
                e = mk(K_BD, BRB, NO, NO, NO, NO, NO);
            8'h16: e = mk(K_C, GB, NO, NO, NO, NO, NO);
            8'h17: e = mk(K_B, GB, NO, NO, NO, NO, NO);
            8'h21, 8'h23, 8'h25, 8'h27: e = mk(K_O, GW, GB, GW, GB, GW, GB);
            8'h24, 8'h26, 8'h2c, 8'h2d: e = mk(K_O, GW, GB, GB, GW, GB, NO);
            8'h28, 8'h29, 8'h34, 8'h35: e = mk(K_O, GW, GB, GB, NO, NO, NO);
            8'h2a, 8'h2b, 8'h38: e = mk(K_O, GW, GB, GB, GB, NO, NO);
            8'h2e, 8'h2f: e = mk(K_O, GW, GB, GB, GB, GW, GB);
            8'h30, 8'h31: e = mk(K_BD, BRW, NO, NO, NO, NO, NO);
            8'h32, 8'h3c, 8'h3e: e = mk(K_O, GW, GL, NO, NO, NO, NO);
            8'h33: e = mk(K_O, GW, GB, NO, NO, NO, NO);
            8'h99, 8'h9b: e = mk(K_O, GB, GW, NO, NO, NO, NO);
            8'h36: e = mk(K_O, GW, GB, GL, NO, NO, NO);
            8'h3d: e = mk(K_BD, GW, GW, GW, BRW, NO, NO);
            8'h3f, 8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hbb, 8'hbc,
            8'hbd, 8'hbe, 8'hbf:
                e = mk(K_O, GW, NO, NO, NO, NO, NO);
            8'h40, 8'h42, 8'h44, 8'h46, 8'h50, 8'h51, 8'h52:
                e = mk(K_O, GF, GF, NO, NO, NO, NO);
            8'h41, 8'h43, 8'h45, 8'h47: e = mk(K_O, GF, GF, GF, NO, NO, NO);
            8'h48: e = mk(K_O, GF, GB, NO, NO, NO, NO);
            8'h49: e = mk(K_O, GF, GW, NO, NO, NO, NO);
            8'h4a, 8'h4b: e = mk(K_O, GF, GL, NO, NO, NO, NO);
            8'h4c: e = mk(K_O, GB, GF, NO, NO, NO, NO);
            8'h4d: e = mk(K_O, GW, GF, NO, NO, NO, NO);
            8'h4e: e = mk(K_O, GL, GF, NO, NO, NO, NO);
            8'h4f: e = mk(K_BD, GF, GF, GF, BRW, NO, NO);
            8'h53: e = mk(K_O, GF, NO, NO, NO, NO, NO);
            8'h54: e = mk(K_O, GF, GB, GF, GL, GF, NO);
            8'h55: e = mk(K_O, GF, GW, GB, NO, NO, NO);
            8'h56: e = mk(K_O, GF, GQ, NO, NO, NO, NO);
            8'h58, 8'ha0, 8'ha2, 8'ha4, 8'ha6, 8'ha8, 8'haa, 8'hac, 8'hae,
            8'hb0, 8'hb1, 8'hb2, 8'hb3:
                e = mk(K_O, GW, GW, NO, NO, NO, NO);
            8'h60, 8'h62, 8'h64, 8'h66, 8'h70, 8'h71, 8'h72, 8'h7d:
                e = mk(K_O, GQ, GQ, NO, NO, NO, NO);
            8'h61, 8'h63, 8'h65, 8'h67: e = mk(K_O, GQ, GQ, GQ, NO, NO, NO);
            8'h68: e = mk(K_O, GQ, GB, NO, NO, NO, NO);
            8'h69: e = mk(K_O, GQ, GW, NO, NO, NO, NO);
            8'h6a, 8'h6b, 8'h7e: e = mk(K_O, GQ, GL, NO, NO, NO, NO);
            8'h6c: e = mk(K_O, GB, GQ, NO, NO, NO, NO);
            8'h6d: e = mk(K_O, GW, GQ, NO, NO, NO, NO);
            8'h6e: e = mk(K_O, GL, GQ, NO, NO, NO, NO);
            8'h6f: e = mk(K_BD, GQ, GQ, GQ, BRW, NO, NO);
            8'h73, 8'h7c, 8'h7f: e = mk(K_O, GQ, NO, NO, NO, NO, NO);
            8'h74: e = mk(K_O, GQ, GB, GQ, GL, GQ, NO);
            8'h75: e = mk(K_O, GQ, GW, GB, NO, NO, NO);
            8'h76: e = mk(K_O, GQ, GF, NO, NO, NO, NO);
            8'h78, 8'h9c: e = mk(K_O, GB, GL, GL, NO, NO, NO);
            8'h79: e = mk(K_O, GB, GQ, GQ, NO, NO, NO);
            8'h7a: e = mk(K_O, GL, GL, GL, GQ, NO, NO);
            8'h7b: e = mk(K_O, GL, GQ, GL, GL, NO, NO);
            8'h80, 8'h82, 8'h84, 8'h86, 8'h88, 8'h8a, 8'h8c, 8'h8e, 8'h90, 8'h91,
            8'h92, 8'h93:
                e = mk(K_O, GB, GB, NO, NO, NO, NO);
            8'h81, 8'h83, 8'h85, 8'h87, 8'h89, 8'h8b, 8'h8d:
                e = mk(K_O, GB, GB, GB, NO, NO, NO);
            8'h8f: e = mk(K_B, GB, GB, GB, CSW, NO, NO);
            8'h94, 8'h95, 8'h96, 8'h97, 8'h9f: e = mk(K_O, GB, NO, NO, NO, NO, NO);
            8'h9d: e = mk(K_BD, GB, GB, GB, BRW, NO, NO);
            8'ha1, 8'ha3, 8'ha5, 8'ha7, 8'ha9, 8'hab, 8'had:
                e = mk(K_O, GW, GW, GW, NO, NO, NO);
            8'haf: e = mk(K_B, GW, GW, GW, CSW, NO, NO);
            8'hc0, 8'hc2, 8'hc4, 8'hc6, 8'hc8, 8'hca, 8'hcc, 8'hce, 8'hd0, 8'hd1,
            8'hd2, 8'hd3, 8'hd8, 8'hd9, 8'hda, 8'hdb, 8'hde:
                e = mk(K_O, GL, GL, NO, NO, NO, NO);
            8'hc1, 8'hc3, 8'hc5, 8'hc7, 8'hc9, 8'hcb, 8'hcd:
                e = mk(K_O, GL, GL, GL, NO, NO, NO);
            8'hcf: e = mk(K_B, GL, GL, GL, CSW, NO, NO);
            8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'hdc, 8'hdd, 8'hdf:
                e = mk(K_O, GL, NO, NO, NO, NO, NO);
            8'he0, 8'he1, 8'he2, 8'he3, 8'he4, 8'he5, 8'he6, 8'he7:
                e = mk(K_BD, GL, GB, BRB, NO, NO, NO);
            8'he8, 8'he9: e = mk(K_BD, GL, BRB, NO, NO, NO, NO);
            8'hea, 8'heb, 8'hec, 8'hed, 8'hee, 8'hef:
                e = mk(K_O, GL, GB, GB, GL, NO, NO);
            8'hf0: e = mk(K_O, GL, GL, GB, GB, NO, NO);
            8'hf1: e = mk(K_BD, GL, GL, GL, BRW, NO, NO);
            8'hf2, 8'hf3: e = mk(K_BD, GL, GL, BRB, NO, NO, NO);
            8'hf4, 8'hf5: e = mk(K_BD, GL, BRB, NO, NO, NO, NO);
            8'hf6: e = mk(K_O, GL, GB, NO, NO, NO, NO);
            8'hf7: e = mk(K_O, GL, GW, NO, NO, NO, NO);
            8'hf8: e = mk(K_O, GB, GW, GB, GB, GW, GB);
            8'hf9: e = mk(K_O, GL, GW, GB, NO, NO, NO);
            8'hfa: e = mk(K_C, GB, GB, NO, NO, NO, NO);
            8'hfb: e = mk(K_C, GL, GB, NO, NO, NO, NO);
            default: e = mk(K_O, NO, NO, NO, NO, NO, NO);
        endcase
        return e;
    endfunction

endpackage

### rtl/vbts_decoder.sv
// Byte-serial instruction measurer: input register, one-step decode, record push.
// Depends on vbts_pkg and the assertion macro header.
`include "vax_branch_target_scanner_unit_defines.svh"

module vbts_decoder
    import vbts_pkg::*;
#(
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_beat_t in_beat,
    input  cfg_t     cfg,
    input  logic     room,
    output push_t    push
);

    localparam int LV_W = (ADDR_WIDTH > 32) ? ADDR_WIDTH : 32;

    logic                  in_valid_reg;
    in_beat_t              in_reg;
    logic                  fire;

    phase_t                phase_reg, phase_next;
    logic [7:0]            opcode_reg, opcode_next;
    logic [2:0]            pos_reg, pos_next;
    logic                  indexed_reg, indexed_next;
    xk_t                   xk_reg, xk_next;
    logic [3:0]            xsize_reg, xsize_next;
    logic [3:0]            left_reg, left_next;
    logic [31:0]           acc_reg, acc_next;
    logic [ADDR_WIDTH-1:0] start_reg, start_next;
    logic [ADDR_WIDTH-1:0] baddr_reg, baddr_next;
    logic [LV_W-1:0]       lv_reg, lv_next;
    logic                  lic_reg, lic_next;
    logic [32:0]           skip_reg, skip_next;
    logic                  cbad_reg, cbad_next;

    logic                  fin_emit;
    logic                  fin_call;
    logic [LV_W-1:0]       fin_tgt;
    logic                  end_rec;
    logic [ADDR_WIDTH-1:0] end_addr;
    logic                  end_trunc;

    assign fire     = in_valid_reg && room;
    assign in_ready = !in_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_reg <= in_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_OPCODE;
            opcode_reg  <= '0;
            pos_reg     <= '0;
            indexed_reg <= 1'b0;
            xk_reg      <= XK_SKIP;
            xsize_reg   <= '0;
            left_reg    <= '0;
            acc_reg     <= '0;
            start_reg   <= '0;
            baddr_reg   <= '0;
            lv_reg      <= '0;
            lic_reg     <= 1'b0;
            skip_reg    <= '0;
            cbad_reg    <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            opcode_reg  <= opcode_next;
            pos_reg     <= pos_next;
            indexed_reg <= indexed_next;
            xk_reg      <= xk_next;
            xsize_reg   <= xsize_next;
            left_reg    <= left_next;
            acc_reg     <= acc_next;
            start_reg   <= start_next;
            baddr_reg   <= baddr_next;
            lv_reg      <= lv_next;
            lic_reg     <= lic_next;
            skip_reg    <= skip_next;
            cbad_reg    <= cbad_next;
        end
    end

    // one byte of decode: opcode, specifier, extension or case-table step, then operand advance
    always_comb
    begin : step_blk
        logic [ADDR_WIDTH-1:0] a;
        phase_t                ph;
        rom_ent_t              ent;
        op_t                   op;
        logic [3:0]            mode;
        logic [3:0]            n;
        xk_t                   kd;
        logic                  do_done;
        logic                  do_next;
        logic                  do_fin;
        logic                  done_c;
        logic [LV_W-1:0]       done_v;
        logic [31:0]           acc_new;
        logic [3:0]            sidx;
        logic [63:0]           v64;
        logic [1:0]            cls;
        logic [63:0]           ra64;
        logic [ADDR_WIDTH-1:0] rel_addr;

        ra64 = 64'(in_reg.region_addr);
        a    = in_reg.first_byte ? ra64[ADDR_WIDTH-1:0] : baddr_reg;
        ph   = in_reg.first_byte ? PH_OPCODE : phase_reg;

        phase_next   = ph;
        opcode_next  = opcode_reg;
        pos_next     = pos_reg;
        indexed_next = indexed_reg;
        xk_next      = xk_reg;
        xsize_next   = xsize_reg;
        left_next    = left_reg;
        acc_next     = acc_reg;
        start_next   = start_reg;
        lv_next      = lv_reg;
        lic_next     = lic_reg;
        skip_next    = skip_reg;
        cbad_next    = cbad_reg;
        do_done      = 1'b0;
        do_next      = 1'b0;
        do_fin       = 1'b0;
        done_c       = 1'b0;
        done_v       = '0;
        n            = '0;
        kd           = XK_SKIP;
        mode         = in_reg.code_byte[7:4];
        acc_new      = acc_reg;
        v64          = '0;
        rel_addr     = '0;
        sidx         = xsize_reg - left_reg;
        ent          = opcode_rom(opcode_reg);
        op           = ent.ops[(pos_reg < 3'd6) ? pos_reg : 3'd0];

        case (ph)
            PH_OPCODE:
            begin
                start_next  = a;
                opcode_next = in_reg.code_byte;
                pos_next    = '0;
                lic_next    = 1'b0;
                lv_next     = '0;
                cbad_next   = 1'b0;
                do_next     = 1'b1;
            end
            PH_SPEC:
            begin
                if (mode < 4'd4)
                begin
                    do_done = 1'b1;
                    done_c  = !indexed_reg;
                    done_v  = LV_W'(in_reg.code_byte[5:0]);
                end
                else if (mode == 4'd4)
                begin
                    indexed_next = 1'b1;
                end
                else
                begin
                    if (mode >= 4'd10)
                    begin
                        n = (mode < 4'd12) ? 4'd1 : (mode < 4'd14) ? 4'd2 : 4'd4;
                    end
                    if (in_reg.code_byte[3:0] == 4'hf && mode >= 4'd8)
                    begin
                        if (mode == 4'd8)
                        begin
                            case (op)
                                GB:      n = 4'd1;
                                GW:      n = 4'd2;
                                GQ:      n = 4'd8;
                                default: n = 4'd4;
                            endcase
                            if (op == GB || op == GW || op == GL)
                            begin
                                kd = XK_IMM;
                            end
                        end
                        else if (mode == 4'd9)
                        begin
                            n = 4'd4;
                        end
                        else if (!mode[0])
                        begin
                            kd = XK_REL;
                        end
                    end
                    if (indexed_reg)
                    begin
                        kd = XK_SKIP;
                    end
                    if (n == 4'd0)
                    begin
                        do_done = 1'b1;
                    end
                    else
                    begin
                        xk_next    = kd;
                        xsize_next = n;
                        left_next  = n;
                        acc_next   = '0;
                        phase_next = PH_EXT;
                    end
                end
            end
            PH_EXT:
            begin
                if (sidx < 4'd4)
                begin
                    acc_new = acc_reg | (32'(in_reg.code_byte) << {sidx[1:0], 3'b000});
                end
                acc_next  = acc_new;
                left_next = left_reg - 4'd1;
                if (left_next == 4'd0)
                begin
                    do_done = 1'b1;
                    case (xk_reg)
                        XK_IMM:
                        begin
                            done_c = 1'b1;
                            done_v = LV_W'(acc_new);
                        end
                        XK_REL:
                        begin
                            case (xsize_reg)
                                4'd1:    v64 = {{56{acc_new[7]}}, acc_new[7:0]};
                                4'd2:    v64 = {{48{acc_new[15]}}, acc_new[15:0]};
                                default: v64 = {{32{acc_new[31]}}, acc_new};
                            endcase
                            // wrap at the address width before widening
                            rel_addr = a + ADDR_WIDTH'(1) + v64[ADDR_WIDTH-1:0];
                            done_c   = 1'b1;
                            done_v   = LV_W'(rel_addr);
                        end
                        default:
                        begin
                            done_c = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                if (skip_reg == '0)
                begin
                    do_fin = 1'b1;
                end
                else
                begin
                    skip_next = skip_reg - 33'd1;
                end
            end
        endcase

        if (do_done)
        begin
            lv_next  = done_c ? done_v : '0;
            lic_next = done_c;
            pos_next = pos_reg + 3'd1;
            do_next  = 1'b1;
        end

        ent = opcode_rom(opcode_next);
        op  = ent.ops[(pos_next < 3'd6) ? pos_next : 3'd0];
        if (do_next)
        begin
            if (pos_next >= 3'd6 || op == NO)
            begin
                do_fin = 1'b1;
            end
            else if (op == BRB || op == BRW)
            begin
                xk_next    = XK_REL;
                xsize_next = (op == BRW) ? 4'd2 : 4'd1;
                left_next  = (op == BRW) ? 4'd2 : 4'd1;
                acc_next   = '0;
                phase_next = PH_EXT;
            end
            else if (op == CSW)
            begin
                if (!lic_next)
                begin
                    cbad_next = 1'b1;
                    do_fin    = 1'b1;
                end
                else
                begin
                    skip_next  = {lv_next[31:0], 1'b1};
                    phase_next = PH_CASE;
                end
            end
            else
            begin
                indexed_next = 1'b0;
                phase_next   = PH_SPEC;
            end
        end

        cls      = ent.kind[1:0];
        fin_emit = 1'b0;
        fin_call = (cls == CLS_C);
        fin_tgt  = '0;
        if (do_fin)
        begin
            phase_next = PH_OPCODE;
            fin_emit   = (cfg.report_calls && cls == CLS_C) ||
                         (cfg.report_branches && (cls == CLS_B || cls == CLS_R));
            if (lic_next && ((cls == CLS_B && ent.kind[2]) || cls == CLS_C))
            begin
                fin_tgt = lv_next;
            end
        end

        baddr_next = a + ADDR_WIDTH'(1);
        end_rec    = in_reg.last_byte;
        end_trunc  = (phase_next != PH_OPCODE);
        end_addr   = end_trunc ? start_next : baddr_next;
        if (in_reg.last_byte)
        begin
            phase_next = PH_OPCODE;
        end
    end

    // record assembly
    always_comb
    begin : rec_blk
        logic [63:0] sa64;
        logic [63:0] ea64;
        logic [63:0] ta64;

        sa64 = 64'(start_next);
        ea64 = 64'(end_addr);
        ta64 = 64'(fin_tgt);
        push.v0             = fire && fin_emit;
        push.r0.record_kind = fin_call ? REC_CALL : REC_BRANCH;
        push.r0.instr_addr  = sa64[31:0];
        push.r0.target_addr = ta64[31:0];
        push.r0.status      = cbad_next ? ST_CASE_LIMIT : ST_OK;
        push.r0.last_of_run = !end_rec;
        push.v1             = fire && end_rec;
        push.r1.record_kind = REC_END;
        push.r1.instr_addr  = ea64[31:0];
        push.r1.target_addr = '0;
        push.r1.status      = end_trunc ? ST_TRUNC : ST_OK;
        push.r1.last_of_run = 1'b1;
    end

    `VBTS_ASSERT_NEXT(a_end_resyncs, fire && in_reg.last_byte, phase_reg == PH_OPCODE,
        "decoder not at an opcode boundary after a region end")
    `VBTS_ASSERT_NOW(a_push_needs_room, push.v0 || push.v1, room,
        "record pushed without queue room")
    `VBTS_ASSERT_NOW(a_case_only_if_const, fire && phase_next == PH_CASE, lic_next,
        "case table skip started with non-constant limit")

endmodule

### rtl/vbts_rec_fifo.sv
// Small record queue: up to two pushes and one pop per cycle.
// Depends on vbts_pkg.
module vbts_rec_fifo
    import vbts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  room,
    output logic  out_valid,
    input  logic  out_ready,
    output rec_t  out_rec
);

    localparam int PW = $clog2(REC_FIFO_DEPTH);

    rec_t          mem [REC_FIFO_DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [PW:0]   cnt_reg, cnt_next;
    logic          pop;
    logic [PW:0]   npush;

    assign out_valid = (cnt_reg != '0);
    assign out_rec   = mem[rd_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (cnt_reg <= (PW+1)'(REC_FIFO_DEPTH - 2));
    assign npush     = (PW+1)'(push.v0) + (PW+1)'(push.v1);

    always_comb
    begin
        wr_next  = wr_reg + PW'(npush);
        rd_next  = rd_reg + PW'(pop);
        cnt_next = cnt_reg + npush - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem[wr_reg] <= push.r0;
            if (push.v1)
            begin
                mem[wr_reg + PW'(1)] <= push.r1;
            end
        end
        else if (push.v1)
        begin
            mem[wr_reg] <= push.r1;
        end
    end

endmodule

### rtl/vax_branch_target_scanner_unit.sv
// Top level of the VAX branch target scanner: stream ports, config registers.
// Depends on vbts_pkg, vbts_decoder and vbts_rec_fifo.
//
// Usage:
//   s_* carries code bytes, one per beat. s_tuser = first_byte starts a region
//   at the address in s_tdata; s_tlast marks the final byte of a region.
//   m_* carries records: one per reported call/branch/return/case, plus an end
//   record per region. m_tlast marks the last record caused by one byte.
//   cfg_* writes report_calls (index 0) and report_branches (index 1); always
//   ready, write only while the block is idle.
// Path: each beat is registered in the decoder; its records go via the record queue.
// Throughput: one byte per cycle while each byte yields at most one record;
//   a byte yielding two records costs a second output beat. The four-entry
//   record queue sets this: input is held once fewer than two slots are free.
// Reset: decode state clears to an opcode boundary at address 0, both enables
//   set, record queue empty.
// Stall: while m_tready is low the queue fills and s_tready drops; nothing is
//   lost or reordered.
module vax_branch_target_scanner_unit
    import vbts_pkg::*;
#(
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // code_byte[7:0], region_addr[39:8]
    input  logic                 s_tuser,   // first_byte
    input  logic                 s_tlast,   // last_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,   // instr_addr, target_addr, status, zero pad
    output logic [1:0]           m_tuser,   // record_kind
    output logic                 m_tlast,   // last_of_run
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data
);

    cfg_t     cfg_reg;
    in_beat_t beat;
    push_t    push;
    logic     room;
    rec_t     rec;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.report_calls    <= 1'b1;
            cfg_reg.report_branches <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_REPORT_CALLS:    cfg_reg.report_calls    <= cfg_data;
                REG_REPORT_BRANCHES: cfg_reg.report_branches <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign beat.code_byte   = s_tdata[7:0];
    assign beat.region_addr = s_tdata[39:8];
    assign beat.first_byte  = s_tuser;
    assign beat.last_byte   = s_tlast;

    vbts_decoder #(
        .ADDR_WIDTH(ADDR_WIDTH)
    ) u_dec (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_beat  (beat),
        .cfg      (cfg_reg),
        .room     (room),
        .push     (push)
    );

    vbts_rec_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (rec)
    );

    assign m_tdata = {6'd0, rec.status, rec.target_addr, rec.instr_addr};
    assign m_tuser = rec.record_kind;
    assign m_tlast = rec.last_of_run;

endmodule
